@@ design/gss_pkg.sv @@
// Package: shared constants, types and the Gaussian weight table for the smoother.
`timescale 1ns / 1ps
package gss_pkg;
    localparam int MAX_HALF_WIDTH = 7;
    localparam int MAG_BITS       = 16;
    localparam int MAX_BINS       = 1025;
    localparam int STORE_DEPTH    = 2 * MAX_HALF_WIDTH + 1;
    localparam int IDX_BITS       = 11;
    localparam int HW_BITS        = 3;
    localparam int W_BITS         = 16;
    localparam int ACC_BITS       = MAG_BITS + W_BITS + 4;
    localparam int WSUM_BITS      = W_BITS + 4;
    localparam int Q_DEPTH        = 4;
    localparam int Q_PTR_BITS     = 2;
    localparam int TAP_BITS       = 4;
    localparam int DIV_BITS       = 6;
    localparam logic [HW_BITS-1:0] HW_RESET = 3'd3;

    // One queued job: a window snapshot and the bins it still has to emit.
    typedef struct packed {
        logic [STORE_DEPTH-1:0][MAG_BITS-1:0] win;
        logic [IDX_BITS-1:0]                  newest;
        logic [IDX_BITS-1:0]                  first;
        logic [IDX_BITS-1:0]                  stop;
        logic [HW_BITS-1:0]                   hw;
        logic                                 last;
    } t_job;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } t_back_state;

    // Q1.15 weight for half width h, tap distance d (d <= h).
    function automatic logic [W_BITS-1:0] weight(input logic [HW_BITS-1:0] h,
                                                 input logic [HW_BITS-1:0] d);
        logic [W_BITS-1:0] w;
        w = '0;
        case ({h, d})
            {3'd1, 3'd0}: w = 16'd32768; {3'd1, 3'd1}: w = 16'd19875;
            {3'd2, 3'd0}: w = 16'd32768; {3'd2, 3'd1}: w = 16'd28918;
            {3'd2, 3'd2}: w = 16'd19875;
            {3'd3, 3'd0}: w = 16'd32768; {3'd3, 3'd1}: w = 16'd30997;
            {3'd3, 3'd2}: w = 16'd26239; {3'd3, 3'd3}: w = 16'd19875;
            {3'd4, 3'd0}: w = 16'd32768; {3'd4, 3'd1}: w = 16'd31760;
            {3'd4, 3'd2}: w = 16'd28918; {3'd4, 3'd3}: w = 16'd24735;
            {3'd4, 3'd4}: w = 16'd19875;
            {3'd5, 3'd0}: w = 16'd32768; {3'd5, 3'd1}: w = 16'd32119;
            {3'd5, 3'd2}: w = 16'd30249; {3'd5, 3'd3}: w = 16'd27370;
            {3'd5, 3'd4}: w = 16'd23794; {3'd5, 3'd5}: w = 16'd19875;
            {3'd6, 3'd0}: w = 16'd32768; {3'd6, 3'd1}: w = 16'd32316;
            {3'd6, 3'd2}: w = 16'd30997; {3'd6, 3'd3}: w = 16'd28918;
            {3'd6, 3'd4}: w = 16'd26239; {3'd6, 3'd5}: w = 16'd23155;
            {3'd6, 3'd6}: w = 16'd19875;
            {3'd7, 3'd0}: w = 16'd32768; {3'd7, 3'd1}: w = 16'd32435;
            {3'd7, 3'd2}: w = 16'd31457; {3'd7, 3'd3}: w = 16'd29893;
            {3'd7, 3'd4}: w = 16'd27832; {3'd7, 3'd5}: w = 16'd25390;
            {3'd7, 3'd6}: w = 16'd22694; {3'd7, 3'd7}: w = 16'd19875;
            default: w = '0;
        endcase
        return w;
    endfunction
endpackage

@@ design/gaussian_spectrum_smoother_core.sv @@
// Top level of the Gaussian spectrum smoother.
`timescale 1ns / 1ps
// Smooths a frame of 16-bit magnitude bins with a Gaussian window of half width h
// (register, 1..7, latched at each frame's first bin). Results lag input by h bins
// and the last bin flushes the rest. The front end takes a bin each cycle while
// its four-entry job queue has room; the back end computes each result with one
// tap per cycle and a one-bit-per-cycle divider, so sustained throughput is set
// by that unit.
module gaussian_spectrum_smoother_core import gss_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [HW_BITS-1:0]  i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [MAG_BITS-1:0] i_magnitude,
    input  logic                i_last_bin,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [MAG_BITS-1:0] o_smoothed,
    output logic [IDX_BITS-1:0] o_bin_index,
    output logic                o_frame_end
);
    t_job job_in, job_out;
    logic job_push, q_full, q_empty, q_pop;

    gss_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_magnitude(i_magnitude),
        .i_last_bin(i_last_bin), .o_job_valid(job_push), .i_job_full(q_full),
        .o_job(job_in)
    );

    gss_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(job_push), .i_job(job_in),
        .o_full(q_full), .i_pop(q_pop), .o_empty(q_empty), .o_job(job_out)
    );

    gss_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(q_empty), .i_job(job_out),
        .o_pop(q_pop), .o_valid(o_valid), .i_stall(i_stall), .o_smoothed(o_smoothed),
        .o_bin_index(o_bin_index), .o_frame_end(o_frame_end)
    );
endmodule

@@ design/gss_front.sv @@
// Front end: shifts bins into the window, tracks the frame and builds jobs.
`timescale 1ns / 1ps
module gss_front import gss_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [HW_BITS-1:0]  i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [MAG_BITS-1:0] i_magnitude,
    input  logic                i_last_bin,
    output logic                o_job_valid,
    input  logic                i_job_full,
    output t_job                o_job
);
    logic [HW_BITS-1:0]                   r_half_width;
    logic [HW_BITS-1:0]                   r_frame_hw;
    logic [IDX_BITS-1:0]                  r_bin_count;
    logic [STORE_DEPTH-1:0][MAG_BITS-1:0] r_win;
    logic [STORE_DEPTH-1:0][MAG_BITS-1:0] n_win;
    logic [HW_BITS-1:0] hw_eff;
    logic [HW_BITS-1:0] hw_use;
    logic               last;
    logic               emit;
    logic               accept;
    logic [IDX_BITS:0]  first_s;

    // Clamp the register to the legal half-width range.
    always_comb begin
        hw_eff = (r_half_width == '0) ? HW_BITS'(1) : r_half_width;
        if (hw_eff > HW_BITS'(MAX_HALF_WIDTH)) hw_eff = HW_BITS'(MAX_HALF_WIDTH);
    end

    assign hw_use  = (r_bin_count == '0) ? hw_eff : r_frame_hw;
    assign last    = i_last_bin || (r_bin_count >= IDX_BITS'(MAX_BINS - 1));
    assign first_s = {1'b0, r_bin_count} - {{(IDX_BITS+1-HW_BITS){1'b0}}, hw_use};
    assign emit    = last || !first_s[IDX_BITS];
    assign o_stall = i_job_full;
    assign accept  = i_valid && !o_stall;

    // Window shift, newest first.
    always_comb begin
        n_win = {r_win[STORE_DEPTH-2:0], i_magnitude};
    end

    // Job that holds every result this bin releases.
    always_comb begin
        o_job_valid = accept && emit;
        o_job.win    = n_win;
        o_job.newest = r_bin_count;
        o_job.first  = first_s[IDX_BITS] ? '0 : first_s[IDX_BITS-1:0];
        o_job.stop   = last ? r_bin_count : first_s[IDX_BITS-1:0];
        o_job.hw     = hw_use;
        o_job.last   = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= HW_RESET;
            r_frame_hw   <= HW_RESET;
            r_bin_count  <= '0;
            r_win        <= '0;
        end else begin
            if (i_cfg_we) r_half_width <= i_cfg_data;
            if (accept) begin
                r_win      <= n_win;
                r_frame_hw <= hw_use;
                r_bin_count <= last ? '0 : r_bin_count + IDX_BITS'(1);
            end
        end
    end
endmodule

@@ design/gss_queue.sv @@
// Small job queue between the front and back ends.
`timescale 1ns / 1ps
module gss_queue import gss_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);
    t_job                r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wp;
    logic [Q_PTR_BITS-1:0] r_rp;
    logic [Q_PTR_BITS:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_PTR_BITS+1)'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + Q_PTR_BITS'(1);
            if (i_pop)  r_rp <= r_rp + Q_PTR_BITS'(1);
            r_cnt <= r_cnt + (Q_PTR_BITS+1)'(i_push) - (Q_PTR_BITS+1)'(i_pop);
        end
    end
endmodule

@@ design/gss_back.sv @@
// Back end: tap-serial weighted sum and bit-serial division for each result bin.
`timescale 1ns / 1ps
module gss_back import gss_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  t_job                i_job,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [MAG_BITS-1:0] o_smoothed,
    output logic [IDX_BITS-1:0] o_bin_index,
    output logic                o_frame_end
);
    t_back_state         r_state, n_state;
    logic [IDX_BITS-1:0] r_c, n_c;
    logic [TAP_BITS-1:0] r_tap, n_tap;
    logic [ACC_BITS-1:0] r_acc, n_acc;
    logic [WSUM_BITS-1:0] r_wsum, n_wsum;
    logic [ACC_BITS-1:0] n_dvd;
    logic [MAG_BITS-1:0] r_quo, n_quo;
    logic [DIV_BITS-1:0] r_dcnt, n_dcnt;
    logic [MAG_BITS-1:0] r_out, n_out;
    logic [IDX_BITS-1:0] r_oidx, n_oidx;
    logic                r_oend, n_oend;
    logic                r_ovalid, n_ovalid;

    logic signed [IDX_BITS+1:0] tap_off;
    logic signed [IDX_BITS+1:0] b;
    logic signed [IDX_BITS+1:0] age;
    logic [HW_BITS-1:0]   tap_dist;
    logic [W_BITS-1:0]    w;
    logic                 tap_ok;
    logic [ACC_BITS-1:0]  prod;
    logic                 out_free;

    // Current tap: offset from -h to +h.
    always_comb begin
        tap_off  = $signed({{(IDX_BITS+2-TAP_BITS){1'b0}}, r_tap})
                 - $signed({{(IDX_BITS+2-HW_BITS){1'b0}}, i_job.hw});
        b        = $signed({2'b00, r_c}) + tap_off;
        age      = $signed({2'b00, i_job.newest}) - b;
        tap_dist = tap_off[IDX_BITS+1] ? HW_BITS'(-tap_off) : HW_BITS'(tap_off);
        w        = weight(i_job.hw, tap_dist);
        tap_ok   = !b[IDX_BITS+1] && !age[IDX_BITS+1]
                 && (age < (IDX_BITS+2)'(STORE_DEPTH));
        prod     = tap_ok ? ACC_BITS'(i_job.win[age[TAP_BITS-1:0]] * w) : '0;
    end

    assign out_free    = !r_ovalid || !i_stall;
    assign o_valid     = r_ovalid;
    assign o_smoothed  = r_out;
    assign o_bin_index = r_oidx;
    assign o_frame_end = r_oend;

    // Sequencer: accumulate taps, divide one quotient bit a cycle, then emit.
    always_comb begin
        n_state  = r_state;
        n_c      = r_c;
        n_tap    = r_tap;
        n_acc    = r_acc;
        n_wsum   = r_wsum;
        n_dvd    = '0;
        n_quo    = r_quo;
        n_dcnt   = r_dcnt;
        n_out    = r_out;
        n_oidx   = r_oidx;
        n_oend   = r_oend;
        n_ovalid = r_ovalid && i_stall;
        o_pop    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_c     = i_job.first;
                    n_tap   = '0;
                    n_acc   = '0;
                    n_wsum  = '0;
                    n_state = ST_ACC;
                end
            end
            ST_ACC: begin
                n_acc  = r_acc + prod;
                n_wsum = tap_ok ? r_wsum + WSUM_BITS'(w) : r_wsum;
                n_tap  = r_tap + TAP_BITS'(1);
                if (r_tap == {i_job.hw, 1'b0}) begin
                    n_dvd   = n_acc + ACC_BITS'(n_wsum >> 1);
                    n_quo   = '0;
                    n_dcnt  = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                // Quotient fits in MAG_BITS; shift dividend from the top.
                n_dcnt  = r_dcnt + DIV_BITS'(1);
                n_state = (r_dcnt == DIV_BITS'(ACC_BITS)) ? ST_OUT : ST_DIV;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out    = r_quo;
                    n_oidx   = r_c;
                    n_oend   = i_job.last && (r_c == i_job.newest);
                    if (r_c == i_job.stop) begin
                        o_pop   = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_c     = r_c + IDX_BITS'(1);
                        n_tap   = '0;
                        n_acc   = '0;
                        n_wsum  = '0;
                        n_state = ST_ACC;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Restoring divider datapath: r_part holds the partial remainder and r_dvd
    // the dividend bits still to be shifted in.
    logic [ACC_BITS-1:0] r_dvd;
    logic [ACC_BITS-1:0] r_part;
    logic [ACC_BITS:0]   dtrial;
    assign dtrial = {r_part[ACC_BITS-1:0], r_dvd[ACC_BITS-1]}
                  - {{(ACC_BITS+1-WSUM_BITS){1'b0}}, r_wsum};

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ACC && n_state == ST_DIV) begin
            r_dvd  <= n_dvd;
            r_part <= '0;
        end else if (r_state == ST_DIV && r_dcnt != DIV_BITS'(ACC_BITS)) begin
            r_dvd <= {r_dvd[ACC_BITS-2:0], 1'b0};
            if (!dtrial[ACC_BITS]) r_part <= dtrial[ACC_BITS-1:0];
            else r_part <= {r_part[ACC_BITS-2:0], r_dvd[ACC_BITS-1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c    <= n_c;
        r_tap  <= n_tap;
        r_acc  <= n_acc;
        r_wsum <= n_wsum;
        r_dcnt <= n_dcnt;
        r_out  <= n_out;
        r_oidx <= n_oidx;
        r_oend <= n_oend;
        if (r_state == ST_ACC && n_state == ST_DIV) r_quo <= '0;
        else if (r_state == ST_DIV && r_dcnt != DIV_BITS'(ACC_BITS))
            r_quo <= {r_quo[MAG_BITS-2:0], !dtrial[ACC_BITS]};
        else r_quo <= n_quo;
    end
endmodule
